@@ src/tlge_pkg.sv @@
// Package with the shared constants, types and codes of the Life engine.
`timescale 1ns / 1ps
package tlge_pkg;

    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = 7;
    localparam int COL_W    = 7;
    localparam int REG_W    = 8;
    localparam int GEN_W    = 16;
    localparam int IDX_W    = 1;

    localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_RUN      = 2'd1,
        CMD_READ     = 2'd2,
        CMD_READ_ALT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ASEL_UP,
        ASEL_MID,
        ASEL_DN
    } addr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_CAP,
        ST_W_WR,
        ST_R_RD,
        ST_R_CAP,
        ST_G_START,
        ST_G_UP,
        ST_G_MID,
        ST_G_DN,
        ST_G_CAP,
        ST_G_WR,
        ST_G_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic      load;
        addr_sel_t addr_sel;
        logic      cap_up;
        logic      cap_mid;
        logic      cap_dn;
        logic      cap_oth;
        logic      gen_init;
        logic      wr_gen;
        logic      row_next;
        logic      gen_end;
        logic      flip;
        logic      wr_cell;
        logic      out_load;
    } ctrl_t;

    typedef struct packed {
        logic n_zero;
        logic last_row;
        logic same_cur;
        logic same_oth;
        logic past_first;
        logic odd_left;
        logic last_gen;
        logic out_free;
    } stat_t;

endpackage

@@ src/tlge_ram.sv @@
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module tlge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tlge_dp.sv @@
// Datapath of the Life engine: grid banks, row window, rule lanes and result register.
`timescale 1ns / 1ps
module tlge_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlge_pkg::ctrl_t                 ctrl,
    output tlge_pkg::stat_t                 stat,
    input  logic                            cfg_we,
    input  logic [tlge_pkg::IDX_W-1:0]      cfg_index,
    input  logic [tlge_pkg::REG_W-1:0]      cfg_data,
    input  logic [1:0]                      in_cmd,
    input  logic [tlge_pkg::ROW_W-1:0]      in_row,
    input  logic [tlge_pkg::COL_W-1:0]      in_col,
    input  logic                            in_cell,
    input  logic [tlge_pkg::GEN_W-1:0]      in_gen,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_cell,
    output logic [1:0]                      out_kind
);
    import tlge_pkg::*;

    logic [REG_W-1:0]    rows_cfg_reg, cols_cfg_reg;
    logic [REG_W-1:0]    eff_rows, eff_cols;
    logic [ROW_W-1:0]    rows_m1;
    logic [COL_W-1:0]    cols_m1;
    logic [ROW_W-1:0]    r_reg;
    logic [COL_W-1:0]    col_reg;
    logic                cell_reg;
    cmd_t                cmd_reg;
    logic [GEN_W-1:0]    n_reg, i_reg;
    logic                cur_reg;
    logic                sc_reg, so_reg;
    logic [MAX_COLS-1:0] up_reg, mid_reg, dn_reg, oth_reg;
    logic                out_valid_reg, out_cell_reg;
    logic [1:0]          out_kind_reg;
    logic [ROW_W-1:0]    up_addr, dn_addr, cur_addr;
    logic [MAX_COLS-1:0] a_q, b_q, cur_q, oth_q;
    logic [MAX_COLS-1:0] res, mid_cell, oth_cell, wdata_oth;
    logic [MAX_COLS-1:0] lane_mask;
    logic                in_grid, row_in, we_cur, we_oth;
    logic                a_we, b_we;
    logic [MAX_COLS-1:0] a_wdata, b_wdata;
    logic [ROW_W-1:0]    a_raddr, b_raddr;
    logic                up_last, mid_last, dn_last;

    always_comb
    begin
        if (rows_cfg_reg == '0)
            eff_rows = REG_W'(1);
        else if (rows_cfg_reg > REG_W'(MAX_ROWS))
            eff_rows = REG_W'(MAX_ROWS);
        else
            eff_rows = rows_cfg_reg;
        if (cols_cfg_reg == '0)
            eff_cols = REG_W'(1);
        else if (cols_cfg_reg > REG_W'(MAX_COLS))
            eff_cols = REG_W'(MAX_COLS);
        else
            eff_cols = cols_cfg_reg;
    end

    assign rows_m1 = ROW_W'(eff_rows - REG_W'(1));
    assign cols_m1 = COL_W'(eff_cols - REG_W'(1));
    assign up_addr = (r_reg == '0) ? rows_m1 : r_reg - ROW_W'(1);
    assign dn_addr = (r_reg == rows_m1) ? '0 : r_reg + ROW_W'(1);
    assign row_in  = {1'b0, r_reg} < eff_rows;
    assign in_grid = row_in && ({1'b0, col_reg} < eff_cols);

    always_comb
    begin
        unique case (ctrl.addr_sel)
            ASEL_UP:  cur_addr = up_addr;
            ASEL_DN:  cur_addr = dn_addr;
            default:  cur_addr = r_reg;
        endcase
    end

    assign a_raddr = cur_reg ? r_reg : cur_addr;
    assign b_raddr = cur_reg ? cur_addr : r_reg;
    assign cur_q   = cur_reg ? b_q : a_q;
    assign oth_q   = cur_reg ? a_q : b_q;

    assign up_last  = up_reg[cols_m1];
    assign mid_last = mid_reg[cols_m1];
    assign dn_last  = dn_reg[cols_m1];

    always_comb
    begin
        logic       ul, ur, ml, mr, dl, dr;
        logic [3:0] cnt;
        for (int j = 0; j < MAX_COLS; j++)
        begin
            ul = (j == 0) ? up_last  : up_reg[(j + MAX_COLS - 1) % MAX_COLS];
            ml = (j == 0) ? mid_last : mid_reg[(j + MAX_COLS - 1) % MAX_COLS];
            dl = (j == 0) ? dn_last  : dn_reg[(j + MAX_COLS - 1) % MAX_COLS];
            if (COL_W'(j) == cols_m1)
            begin
                ur = up_reg[0];
                mr = mid_reg[0];
                dr = dn_reg[0];
            end
            else
            begin
                ur = up_reg[(j + 1) % MAX_COLS];
                mr = mid_reg[(j + 1) % MAX_COLS];
                dr = dn_reg[(j + 1) % MAX_COLS];
            end
            cnt = 4'(ul) + 4'(up_reg[j]) + 4'(ur) + 4'(ml) + 4'(mr)
                + 4'(dl) + 4'(dn_reg[j]) + 4'(dr);
            lane_mask[j] = row_in && (REG_W'(j) < eff_cols);
            if (lane_mask[j])
                res[j] = (cnt == 4'd3) || ((cnt == 4'd2) && mid_reg[j]);
            else
                res[j] = mid_reg[j];
        end
    end

    always_comb
    begin
        mid_cell          = mid_reg;
        oth_cell          = oth_reg;
        mid_cell[col_reg] = cell_reg;
        oth_cell[col_reg] = cell_reg;
    end

    assign we_cur    = ctrl.wr_cell && in_grid;
    assign we_oth    = (ctrl.wr_cell && in_grid) || ctrl.wr_gen;
    assign wdata_oth = ctrl.wr_gen ? res : oth_cell;
    assign a_we      = cur_reg ? we_oth : we_cur;
    assign b_we      = cur_reg ? we_cur : we_oth;
    assign a_wdata   = cur_reg ? wdata_oth : mid_cell;
    assign b_wdata   = cur_reg ? mid_cell : wdata_oth;

    tlge_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_bank_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (r_reg),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_q)
    );

    tlge_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_bank_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (r_reg),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= REG_W'(100);
            cols_cfg_reg  <= REG_W'(100);
            cur_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            i_reg         <= '0;
            sc_reg        <= 1'b1;
            so_reg        <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRID_ROWS)
                    rows_cfg_reg <= cfg_data;
                else
                    cols_cfg_reg <= cfg_data;
            end
            if (ctrl.flip)
                cur_reg <= ~cur_reg;
            if (ctrl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (ctrl.load)
                r_reg <= in_row;
            else if (ctrl.gen_init || ctrl.gen_end)
                r_reg <= '0;
            else if (ctrl.row_next)
                r_reg <= r_reg + ROW_W'(1);
            if (ctrl.gen_init)
                i_reg <= '0;
            else if (ctrl.gen_end)
                i_reg <= i_reg + GEN_W'(1);
            if (ctrl.gen_init || ctrl.gen_end)
            begin
                sc_reg <= 1'b1;
                so_reg <= 1'b1;
            end
            else if (ctrl.wr_gen)
            begin
                // Cells outside the grid in use are plain copies, so only the lanes in use
                // decide whether the grid has settled.
                sc_reg <= sc_reg && (((res ^ mid_reg) & lane_mask) == '0);
                so_reg <= so_reg && (((res ^ oth_reg) & lane_mask) == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd_t'(in_cmd);
            col_reg  <= in_col;
            cell_reg <= in_cell;
            n_reg    <= in_gen;
        end
        if (ctrl.cap_up)
            up_reg <= cur_q;
        if (ctrl.cap_mid)
            mid_reg <= cur_q;
        if (ctrl.cap_dn)
            dn_reg <= cur_q;
        if (ctrl.cap_oth)
            oth_reg <= oth_q;
        if (ctrl.out_load)
        begin
            case (cmd_reg)
                CMD_WRITE:
                begin
                    out_kind_reg <= 2'(CMD_WRITE);
                    out_cell_reg <= 1'b0;
                end
                CMD_RUN:
                begin
                    out_kind_reg <= 2'(CMD_RUN);
                    out_cell_reg <= 1'b0;
                end
                default:
                begin
                    out_kind_reg <= 2'(CMD_READ);
                    out_cell_reg <= in_grid && mid_reg[col_reg];
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cell  = out_cell_reg;
    assign out_kind  = out_kind_reg;

    assign stat.n_zero     = (n_reg == '0);
    assign stat.last_row   = (r_reg == ROW_W'(MAX_ROWS - 1));
    assign stat.same_cur   = sc_reg;
    assign stat.same_oth   = so_reg;
    assign stat.past_first = (i_reg != '0);
    assign stat.odd_left   = ~(n_reg[0] ^ i_reg[0]);
    assign stat.last_gen   = ({1'b0, i_reg} + (GEN_W + 1)'(1)) == {1'b0, n_reg};
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

@@ src/tlge_ctrl.sv @@
// Controller state machine that sequences commands, row sweeps and generations.
`timescale 1ns / 1ps
module tlge_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_cmd,
    input  tlge_pkg::stat_t stat,
    output tlge_pkg::ctrl_t ctrl
);
    import tlge_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        ctrl.addr_sel = ASEL_MID;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    case (cmd_t'(in_cmd))
                        CMD_WRITE: state_next = ST_W_RD;
                        CMD_RUN:   state_next = ST_G_START;
                        default:   state_next = ST_R_RD;
                    endcase
                end
            end
            ST_W_RD:
                state_next = ST_W_CAP;
            ST_W_CAP:
            begin
                ctrl.cap_mid = 1'b1;
                ctrl.cap_oth = 1'b1;
                state_next   = ST_W_WR;
            end
            ST_W_WR:
            begin
                ctrl.wr_cell = 1'b1;
                state_next   = ST_DONE;
            end
            ST_R_RD:
                state_next = ST_R_CAP;
            ST_R_CAP:
            begin
                ctrl.cap_mid = 1'b1;
                state_next   = ST_DONE;
            end
            ST_G_START:
            begin
                if (stat.n_zero)
                    state_next = ST_DONE;
                else
                begin
                    ctrl.gen_init = 1'b1;
                    state_next    = ST_G_UP;
                end
            end
            ST_G_UP:
            begin
                ctrl.addr_sel = ASEL_UP;
                state_next    = ST_G_MID;
            end
            ST_G_MID:
            begin
                ctrl.cap_up = 1'b1;
                state_next  = ST_G_DN;
            end
            ST_G_DN:
            begin
                ctrl.addr_sel = ASEL_DN;
                ctrl.cap_mid  = 1'b1;
                state_next    = ST_G_CAP;
            end
            ST_G_CAP:
            begin
                ctrl.cap_dn  = 1'b1;
                ctrl.cap_oth = 1'b1;
                state_next   = ST_G_WR;
            end
            ST_G_WR:
            begin
                ctrl.wr_gen = 1'b1;
                if (stat.last_row)
                    state_next = ST_G_END;
                else
                begin
                    ctrl.row_next = 1'b1;
                    state_next    = ST_G_UP;
                end
            end
            ST_G_END:
            begin
                if (stat.same_cur)
                begin
                    ctrl.flip  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.same_oth && stat.past_first)
                begin
                    ctrl.flip  = ~stat.odd_left;
                    state_next = ST_DONE;
                end
                else if (stat.last_gen)
                begin
                    ctrl.flip  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.flip    = 1'b1;
                    ctrl.gen_end = 1'b1;
                    state_next   = ST_G_UP;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

@@ src/toroidal_life_generation_engine_unit.sv @@
// Top level of the toroidal Life engine with its stream and configuration ports.
`timescale 1ns / 1ps
// The block keeps a 128 by 128 grid of cells in two row-wide banks and runs rule B3/S23
// on the torus of grid_rows by grid_cols cells set through the configuration port.
// Each input beat carries one command in s_tuser: write a cell, run generations, or read
// a cell. Each command gives exactly one output beat with the command kind in m_tuser
// and, for a read, the cell value in m_tdata.
// A write passes through the states W_RD, W_CAP, W_WR and DONE before its output beat, and a
// read through R_RD, R_CAP and DONE. A run sweeps every one of the 128 stored rows in each
// generation, each row through G_UP, G_MID, G_DN, G_CAP and G_WR, bound by the single read
// port of the current bank, which must fetch the row above, the row itself and the row below.
// A run ends early on a still life or an alternating grid; zero generations skip the sweep.
// One command is worked on at a time; the next beat is taken once the result sits in
// the output register, so a stalled receiver holds one result and blocks only the next.
// Reset restores both size registers to 100, selects bank A as current and empties the
// output register; the grid contents are undefined until written.
module toroidal_life_generation_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // row, col, cell_in, generation_count
    input  logic [1:0]                    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // cell_out
    output logic [1:0]                    m_tuser,   // done_kind
    input  logic                          cfg_we,
    input  logic [tlge_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tlge_pkg::REG_W-1:0]    cfg_data
);
    import tlge_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic  out_cell;

    tlge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tlge_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (s_tuser),
        .in_row    (s_tdata[6:0]),
        .in_col    (s_tdata[13:7]),
        .in_cell   (s_tdata[14]),
        .in_gen    (s_tdata[30:15]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cell  (out_cell),
        .out_kind  (m_tuser)
    );

    assign m_tdata = {7'b0, out_cell};

endmodule

@@ tb/toroidal_life_generation_engine_unit_test.sv @@
// Self-checking testbench for the toroidal Life engine: commands, grid sizes and stalls.
`timescale 1ns / 1ps
module toroidal_life_generation_engine_unit_test;
    import tlge_pkg::*;

    typedef struct {
        bit       cell_val;
        bit [1:0] kind;
    } life_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [REG_W-1:0]     cfg_data;

    bit                   cells [2][MAX_ROWS][MAX_COLS];
    bit                   loaded [MAX_ROWS][MAX_COLS];
    bit                   live_bank;
    logic [REG_W-1:0]     rows_reg;
    logic [REG_W-1:0]     cols_reg;
    life_result_t         pending_q[$];
    int                   mismatches;
    bit                   idle_en;
    int                   hold_left;
    int                   rx_gap;

    toroidal_life_generation_engine_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamp_size(logic [REG_W-1:0] v, int mx);
        if (v == 0)
            return 1;
        return (v > mx) ? mx : int'(v);
    endfunction

    function automatic void step_generation(int nr, int nc, output bit sc, output bit so);
        bit nxt;
        bit old;
        int up;
        int dn;
        int lc;
        int rc;
        int cnt;
        bit o;
        o  = ~live_bank;
        sc = 1'b1;
        so = 1'b1;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            up = (r + nr - 1) % nr;
            dn = (r + 1) % nr;
            for (int c = 0; c < MAX_COLS; c++)
            begin
                old = cells[live_bank][r][c];
                if (r >= nr || c >= nc)
                    nxt = old;
                else
                begin
                    lc  = (c + nc - 1) % nc;
                    rc  = (c + 1) % nc;
                    cnt = cells[live_bank][up][lc] + cells[live_bank][up][c]
                        + cells[live_bank][up][rc] + cells[live_bank][r][lc]
                        + cells[live_bank][r][rc] + cells[live_bank][dn][lc]
                        + cells[live_bank][dn][c] + cells[live_bank][dn][rc];
                    nxt = (cnt == 3) || (cnt == 2 && old);
                end
                if (r < nr && nxt != old)
                    sc = 1'b0;
                if (nxt != cells[o][r][c])
                    so = 1'b0;
                cells[o][r][c] = nxt;
            end
        end
        live_bank = o;
    endfunction

    function automatic void advance_grid(bit [15:0] n);
        int nr;
        int nc;
        bit sc;
        bit so;
        nr = clamp_size(rows_reg, MAX_ROWS);
        nc = clamp_size(cols_reg, MAX_COLS);
        for (int i = 0; i < n; i++)
        begin
            step_generation(nr, nc, sc, so);
            if (sc)
                return;
            if (so && i >= 1)
            begin
                if (((int'(n) - 1 - i) & 1) != 0)
                    live_bank = ~live_bank;
                return;
            end
        end
    endfunction

    function automatic life_result_t predict_command(cmd_t k, bit [6:0] r, bit [6:0] c,
                                                     bit v, bit [15:0] n);
        life_result_t res;
        bit in_grid;
        in_grid = r < clamp_size(rows_reg, MAX_ROWS) && c < clamp_size(cols_reg, MAX_COLS);
        res.cell_val = 1'b0;
        if (k == CMD_WRITE)
        begin
            if (in_grid)
            begin
                cells[0][r][c] = v;
                cells[1][r][c] = v;
                loaded[r][c]   = 1'b1;
            end
            res.kind = CMD_WRITE;
        end
        else if (k == CMD_RUN)
        begin
            advance_grid(n);
            res.kind = CMD_RUN;
        end
        else
        begin
            if (in_grid)
                res.cell_val = cells[live_bank][r][c];
            res.kind = CMD_READ;
        end
        return res;
    endfunction

    task automatic send_cmd(cmd_t k, bit [6:0] r, bit [6:0] c, bit v, bit [15:0] n);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {1'b0, n, v, c, r};
        do
            @(posedge clk);
        while (!s_tready);
        pending_q.push_back(predict_command(k, r, c, v, n));
    endtask

    task automatic drain_and_resize(logic [REG_W-1:0] nr, logic [REG_W-1:0] nc);
        @(posedge clk);
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data  <= nr;
        @(posedge clk);
        cfg_index <= REG_GRID_COLS;
        cfg_data  <= nc;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_reg = nr;
        cols_reg = nc;
    endtask

    task automatic fill_unloaded();
        int nr;
        int nc;
        nr = clamp_size(rows_reg, MAX_ROWS);
        nc = clamp_size(cols_reg, MAX_COLS);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (!loaded[r][c])
                    send_cmd(CMD_WRITE, 7'(r), 7'(c), 1'($urandom_range(0, 1)),
                             16'($urandom));
    endtask

    task automatic random_cmd(bit wide_gen);
        int nr;
        int nc;
        bit [6:0] r;
        bit [6:0] c;
        nr = clamp_size(rows_reg, MAX_ROWS);
        nc = clamp_size(cols_reg, MAX_COLS);
        if ($urandom_range(0, 4) != 0)
        begin
            r = 7'($urandom_range(0, nr - 1));
            c = 7'($urandom_range(0, nc - 1));
        end
        else
        begin
            r = 7'($urandom);
            c = 7'($urandom);
        end
        case ($urandom_range(0, 3))
            0: send_cmd(CMD_WRITE, r, c, 1'($urandom_range(0, 1)), 16'($urandom));
            1: send_cmd(CMD_RUN, 7'($urandom), 7'($urandom), 1'($urandom_range(0, 1)),
                        wide_gen ? 16'($urandom) : 16'($urandom_range(0, 4)));
            2: send_cmd(CMD_READ, r, c, 1'($urandom_range(0, 1)), 16'($urandom));
            default: send_cmd(CMD_READ_ALT, r, c, 1'($urandom_range(0, 1)), 16'($urandom));
        endcase
    endtask

    task automatic test_directed();
        drain_and_resize(8'd5, 8'd5);
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                send_cmd(CMD_WRITE, 7'(r), 7'(c), 1'b0, 16'h0000);
        send_cmd(CMD_WRITE, 7'd3, 7'd2, 1'b1, 16'hFFFF);
        send_cmd(CMD_WRITE, 7'd3, 7'd3, 1'b1, 16'h0000);
        send_cmd(CMD_WRITE, 7'd3, 7'd4, 1'b1, 16'h0000);
        send_cmd(CMD_WRITE, 7'd127, 7'd127, 1'b1, 16'h0000);
        send_cmd(CMD_RUN, 7'd0, 7'd0, 1'b0, 16'd0);
        send_cmd(CMD_READ, 7'd3, 7'd2, 1'b0, 16'h0000);
        send_cmd(CMD_RUN, 7'd127, 7'd127, 1'b1, 16'd1);
        send_cmd(CMD_READ, 7'd2, 7'd3, 1'b0, 16'h0000);
        send_cmd(CMD_READ_ALT, 7'd3, 7'd2, 1'b1, 16'hFFFF);
        send_cmd(CMD_RUN, 7'd0, 7'd0, 1'b0, 16'hFFFF);
        send_cmd(CMD_READ, 7'd4, 7'd3, 1'b0, 16'h0000);
        send_cmd(CMD_READ, 7'd127, 7'd127, 1'b0, 16'h0000);
        send_cmd(CMD_WRITE, 7'd7, 7'd7, 1'b1, 16'h0000);
        send_cmd(CMD_RUN, 7'd0, 7'd0, 1'b0, 16'd3);
        send_cmd(CMD_READ, 7'd7, 7'd7, 1'b0, 16'h0000);
        drain_and_resize(8'd0, 8'd2);
        fill_unloaded();
        send_cmd(CMD_RUN, 7'd0, 7'd0, 1'b0, 16'd1);
        send_cmd(CMD_READ, 7'd0, 7'd1, 1'b0, 16'h0000);
        drain_and_resize(8'd2, 8'd1);
        fill_unloaded();
        send_cmd(CMD_RUN, 7'd0, 7'd0, 1'b0, 16'd2);
        send_cmd(CMD_READ, 7'd1, 7'd0, 1'b0, 16'h0000);
    endtask

    task automatic test_random_sizes();
        for (int p = 0; p < 3; p++)
        begin
            drain_and_resize(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
            fill_unloaded();
            repeat (4) random_cmd(1'b0);
        end
        drain_and_resize(8'd1, 8'd1);
        fill_unloaded();
        repeat (5) random_cmd(1'b1);
    endtask

    task automatic test_output_stall();
        drain_and_resize(8'd5, 8'd6);
        fill_unloaded();
        hold_left = 400;
        repeat (6) random_cmd(1'b0);
    endtask

    task automatic test_size_clamp();
        drain_and_resize(8'd255, 8'd1);
        send_cmd(CMD_WRITE, 7'd127, 7'd0, 1'b1, 16'h0000);
        send_cmd(CMD_WRITE, 7'd100, 7'd0, 1'b1, 16'h0000);
        send_cmd(CMD_WRITE, 7'd3, 7'd1, 1'b1, 16'h0000);
        send_cmd(CMD_READ, 7'd127, 7'd0, 1'b0, 16'h0000);
        send_cmd(CMD_READ_ALT, 7'd100, 7'd0, 1'b0, 16'h0000);
        send_cmd(CMD_READ, 7'd0, 7'd0, 1'b0, 16'h0000);
        drain_and_resize(8'd1, 8'd200);
        send_cmd(CMD_WRITE, 7'd0, 7'd127, 1'b1, 16'h0000);
        send_cmd(CMD_WRITE, 7'd0, 7'd64, 1'b1, 16'h0000);
        send_cmd(CMD_READ, 7'd0, 7'd127, 1'b0, 16'h0000);
        send_cmd(CMD_READ, 7'd0, 7'd64, 1'b0, 16'h0000);
        send_cmd(CMD_READ, 7'd1, 7'd0, 1'b0, 16'h0000);
    endtask

    task automatic test_no_idle();
        drain_and_resize(8'd4, 8'd4);
        idle_en = 1'b0;
        fill_unloaded();
        repeat (12) random_cmd(1'b0);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        life_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected beat kind", int'(m_tuser), -1);
            else
            begin
                want = pending_q.pop_front();
                if (m_tdata[0] != want.cell_val)
                    report_mismatch("cell_out", int'(m_tdata[0]), int'(want.cell_val));
                if (m_tuser != want.kind)
                    report_mismatch("done_kind", int'(m_tuser), int'(want.kind));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!idle_en)
            m_tready <= 1'b1;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rx_gap = int'($urandom_range(1, 12)) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_WRITE;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_GRID_ROWS;
        cfg_data   = '0;
        mismatches = 0;
        idle_en    = 1'b1;
        hold_left  = 0;
        rx_gap     = 0;
        live_bank  = 1'b0;
        rows_reg   = 8'd100;
        cols_reg   = 8'd100;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sizes();
        test_output_stall();
        test_size_clamp();
        test_no_idle();
        @(posedge clk);
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
